>>> sv/m2u_pkg.sv
`default_nettype none

package m2u_pkg;

    // Field widths fixed by the packet format.
    localparam int CABLE_W = 2;
    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int POS_W   = 3;

    localparam int NUM_CABLES_DEF = 3;

    // Code index numbers.
    localparam logic [NIB_W-1:0] CIN_COMMON2     = 4'h2;
    localparam logic [NIB_W-1:0] CIN_COMMON3     = 4'h3;
    localparam logic [NIB_W-1:0] CIN_SYSEX       = 4'h4;
    localparam logic [NIB_W-1:0] CIN_SYSEX_END1  = 4'h5;
    localparam logic [NIB_W-1:0] CIN_VOICE_LO    = 4'h8;
    localparam logic [NIB_W-1:0] CIN_VOICE_2BYTE = 4'hc;
    localparam logic [NIB_W-1:0] CIN_PRESSURE    = 4'hd;
    localparam logic [NIB_W-1:0] CIN_PITCH_BEND  = 4'he;
    localparam logic [NIB_W-1:0] CIN_SINGLE      = 4'hf;

    // Status nibbles and system bytes.
    localparam logic [NIB_W-1:0]  HI_NOTE_OFF      = 4'h8;
    localparam logic [NIB_W-1:0]  HI_CTRL_CHANGE   = 4'hb;
    localparam logic [NIB_W-1:0]  HI_PROG_CHANGE   = 4'hc;
    localparam logic [NIB_W-1:0]  HI_CHAN_PRESSURE = 4'hd;
    localparam logic [NIB_W-1:0]  HI_PITCH_BEND    = 4'he;
    localparam logic [NIB_W-1:0]  HI_SYSTEM        = 4'hf;
    localparam logic [BYTE_W-1:0] BYTE_SYSEX_START = 8'hf0;
    localparam logic [BYTE_W-1:0] BYTE_MTC_QFRAME  = 8'hf1;
    localparam logic [BYTE_W-1:0] BYTE_SONG_POS    = 8'hf2;
    localparam logic [BYTE_W-1:0] BYTE_SONG_SEL    = 8'hf3;
    localparam logic [BYTE_W-1:0] BYTE_SYSEX_END   = 8'hf7;
    localparam logic [BYTE_W-1:0] BYTE_REALTIME    = 8'hf8;

    // Packet lengths and fill positions, counted in bytes including the header.
    localparam logic [POS_W-1:0] LEN_ONE   = 3'd2;
    localparam logic [POS_W-1:0] LEN_TWO   = 3'd3;
    localparam logic [POS_W-1:0] LEN_THREE = 3'd4;

    // Per-cable state as held in the state memory.
    typedef struct packed {
        logic [NIB_W-1:0]  cin;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [POS_W-1:0]  fill;
        logic [POS_W-1:0]  len;
    } t_state;

    // Control flags from the packer to the pipeline.
    typedef struct packed {
        logic emit;
        logic write;
    } t_pk_ctl;

endpackage

`default_nettype wire

>>> sv/m2u_state_mem.sv
`default_nettype none

module m2u_state_mem #(
    parameter int NUM_CABLES = m2u_pkg::NUM_CABLES_DEF,
    parameter int IDX_W      = (NUM_CABLES > 1) ? $clog2(NUM_CABLES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    input  wire logic              i_wr_en,
    input  wire logic [IDX_W-1:0]  i_wr_idx,
    input  wire m2u_pkg::t_state   i_wr_data,
    output m2u_pkg::t_state        o_rd_data
);
    import m2u_pkg::*;

    t_state                mem [NUM_CABLES];
    logic [NUM_CABLES-1:0] r_vld;
    t_state                r_rd;
    logic                  r_rd_vld;
    logic                  r_byp_hit;
    t_state                r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= mem[i_rd_idx];
            r_byp <= i_wr_data;
        end
    end

    // Valid bits make a never written entry read as the all-zero reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[i_rd_idx];
                r_byp_hit <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    // A write in the same cycle as the read of the same entry is forwarded.
    always_comb begin
        if (r_byp_hit) begin
            o_rd_data = r_byp;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

>>> sv/m2u_packer.sv
`default_nettype none

module m2u_packer (
    input  wire m2u_pkg::t_state                   i_state,
    input  wire logic [m2u_pkg::CABLE_W-1:0]       i_cable,
    input  wire logic [m2u_pkg::BYTE_W-1:0]        i_byte,
    output m2u_pkg::t_state                        o_state,
    output m2u_pkg::t_pk_ctl                       o_ctl,
    output logic [m2u_pkg::BYTE_W-1:0]             o_header,
    output logic [m2u_pkg::BYTE_W-1:0]             o_first,
    output logic [m2u_pkg::BYTE_W-1:0]             o_second,
    output logic [m2u_pkg::BYTE_W-1:0]             o_third
);
    import m2u_pkg::*;

    logic [NIB_W-1:0] hi;
    logic [1:0]       pos;
    t_state           ns;
    logic             done;

    assign hi  = i_byte[BYTE_W-1 -: NIB_W];
    assign pos = i_state.fill[1:0];

    always_comb begin
        ns = i_state;
        if (i_state.fill == '0) begin
            ns.fill = LEN_ONE;
            ns.len  = LEN_THREE;
            if (i_state.cin == CIN_SYSEX) begin
                if (i_byte == BYTE_SYSEX_END) begin
                    ns.cin = CIN_SYSEX_END1;
                    ns.len = LEN_ONE;
                end
                ns.b1 = i_byte;
            end else if (hi < HI_NOTE_OFF && i_state.cin >= CIN_VOICE_LO
                         && i_state.cin < CIN_SINGLE) begin
                // Running status: the stored status byte is reused.
                ns.b2   = i_byte;
                ns.fill = LEN_TWO;
                if (!(i_state.cin < CIN_VOICE_2BYTE || i_state.cin == CIN_PITCH_BEND)) begin
                    ns.len = LEN_TWO;
                end
            end else if ((hi >= HI_NOTE_OFF && hi <= HI_CTRL_CHANGE)
                         || hi == HI_PITCH_BEND) begin
                ns.cin = hi;
                ns.b1  = i_byte;
            end else if (hi == HI_PROG_CHANGE || hi == HI_CHAN_PRESSURE) begin
                ns.cin = hi;
                ns.b1  = i_byte;
                ns.len = LEN_TWO;
            end else if (hi == HI_SYSTEM) begin
                if (i_byte == BYTE_SYSEX_START) begin
                    ns.cin = CIN_SYSEX;
                end else if (i_byte == BYTE_MTC_QFRAME || i_byte == BYTE_SONG_SEL) begin
                    ns.cin = CIN_COMMON2;
                    ns.len = LEN_TWO;
                end else if (i_byte == BYTE_SONG_POS) begin
                    ns.cin = CIN_COMMON3;
                end else begin
                    ns.cin = CIN_SINGLE;
                    ns.len = LEN_ONE;
                end
                ns.b1 = i_byte;
            end else begin
                ns.cin = CIN_SINGLE;
                ns.b1  = i_byte;
                ns.len = LEN_ONE;
            end
        end else begin
            case (pos)
                2'd1:    ns.b1  = i_byte;
                2'd2:    ns.b2  = i_byte;
                2'd3:    ns.b3  = i_byte;
                default: ns.cin = i_byte[NIB_W-1:0];
            endcase
            ns.fill = {1'b0, pos} + 3'd1;
            if (i_state.cin == CIN_SYSEX && i_byte == BYTE_SYSEX_END) begin
                ns.cin = CIN_SYSEX + {2'b00, pos};
                ns.len = ns.fill;
            end
        end

        done = (ns.fill >= LEN_ONE) && (ns.len <= ns.fill);
        if (done) begin
            if (ns.len <= 3'd1) begin
                ns.b1 = '0;
            end
            if (ns.len <= 3'd2) begin
                ns.b2 = '0;
            end
            if (ns.len <= 3'd3) begin
                ns.b3 = '0;
            end
            ns.fill = '0;
        end
    end

    always_comb begin
        if (i_byte >= BYTE_REALTIME) begin
            // Real-time bytes pass straight through and leave the state alone.
            o_state     = i_state;
            o_ctl.emit  = 1'b1;
            o_ctl.write = 1'b0;
            o_header    = {2'b00, i_cable, CIN_SINGLE};
            o_first     = i_byte;
            o_second    = '0;
            o_third     = '0;
        end else begin
            o_state     = ns;
            o_ctl.emit  = done;
            o_ctl.write = 1'b1;
            o_header    = {2'b00, i_cable, ns.cin};
            o_first     = ns.b1;
            o_second    = ns.b2;
            o_third     = ns.b3;
        end
    end

endmodule

`default_nettype wire

>>> sv/midi_bytes_to_usb_midi_packets_top.sv
`default_nettype none
// An accepted byte is registered together with its cable's state read; when it completes an
// event packet, the packer's result moves into the output register and shows on o_valid.
// Throughput: one byte per cycle on any mix of cables while i_ready does not stall the output;
// the rate is set by the read-modify-write of the per-cable state memory, whose write is forwarded.
// Reset (i_rst_n low at a clock edge) empties the pipeline and the output register and
// clears the per-cable valid bits, so every cable starts from the all-zero state at once.
module midi_bytes_to_usb_midi_packets_top #(
    parameter int NUM_CABLES = m2u_pkg::NUM_CABLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [m2u_pkg::CABLE_W-1:0]   i_cable,
    input  wire logic [m2u_pkg::BYTE_W-1:0]    i_midi_byte,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [m2u_pkg::BYTE_W-1:0]         o_header_byte,
    output logic [m2u_pkg::BYTE_W-1:0]         o_payload_first,
    output logic [m2u_pkg::BYTE_W-1:0]         o_payload_second,
    output logic [m2u_pkg::BYTE_W-1:0]         o_payload_third
);
    import m2u_pkg::*;

    localparam int IDX_W = (NUM_CABLES > 1) ? $clog2(NUM_CABLES) : 1;
    localparam int EXT_W = (IDX_W > CABLE_W) ? IDX_W : CABLE_W;

    // The pipeline has two steps. On the accepting edge the cable's state entry is read
    // from the state memory. In the following cycle the packer updates that state; once the
    // second step may move on, the new state is written back and a finished event packet moves
    // into the output register. A byte for the same cable right behind gets the written state forwarded.

    logic [EXT_W-1:0]  w_cab_ext;
    logic [IDX_W-1:0]  w_idx;
    logic              w_in_range;
    logic              w_accept;

    logic              r_s1_valid;
    logic [CABLE_W-1:0] r_s1_cable;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [EXT_W-1:0]  w_s1_ext;
    logic [IDX_W-1:0]  w_s1_idx;

    t_state            w_old_state;
    t_state            w_new_state;
    t_pk_ctl           w_ctl;
    logic [BYTE_W-1:0] w_hdr;
    logic [BYTE_W-1:0] w_first;
    logic [BYTE_W-1:0] w_second;
    logic [BYTE_W-1:0] w_third;
    logic              w_s1_go;
    logic              w_wr_en;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_hdr;
    logic [BYTE_W-1:0] r_out_first;
    logic [BYTE_W-1:0] r_out_second;
    logic [BYTE_W-1:0] r_out_third;

    assign w_cab_ext  = EXT_W'(i_cable);
    assign w_idx      = w_cab_ext[IDX_W-1:0];
    assign w_s1_ext   = EXT_W'(r_s1_cable);
    assign w_s1_idx   = w_s1_ext[IDX_W-1:0];
    assign w_in_range = 32'(i_cable) < 32'(NUM_CABLES);

    // The item in the second step may move on unless it has a packet to give and the
    // output register is still holding one that nobody takes this cycle.
    assign w_s1_go  = !(w_ctl.emit && r_out_valid && !i_ready);
    assign o_ready  = !r_s1_valid || w_s1_go;
    assign w_accept = i_valid && o_ready;
    assign w_wr_en  = r_s1_valid && w_s1_go && w_ctl.write;

    m2u_state_mem #(
        .NUM_CABLES (NUM_CABLES),
        .IDX_W      (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept && w_in_range),
        .i_rd_idx  (w_idx),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (w_s1_idx),
        .i_wr_data (w_new_state),
        .o_rd_data (w_old_state)
    );

    m2u_packer u_packer (
        .i_state  (w_old_state),
        .i_cable  (r_s1_cable),
        .i_byte   (r_s1_byte),
        .o_state  (w_new_state),
        .o_ctl    (w_ctl),
        .o_header (w_hdr),
        .o_first  (w_first),
        .o_second (w_second),
        .o_third  (w_third)
    );

    // Bytes on a cable beyond the configured count are taken and dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= w_accept && w_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cable <= i_cable;
            r_s1_byte  <= i_midi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && w_s1_go && w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s1_go && w_ctl.emit) begin
            r_out_hdr    <= w_hdr;
            r_out_first  <= w_first;
            r_out_second <= w_second;
            r_out_third  <= w_third;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_header_byte    = r_out_hdr;
    assign o_payload_first  = r_out_first;
    assign o_payload_second = r_out_second;
    assign o_payload_third  = r_out_third;

endmodule

`default_nettype wire
